[design/frsp_pkg.sv]
package frsp_pkg;

    // Default counter widths
    localparam int POSITION_BITS_DEFAULT = 32;
    localparam int RECORD_BITS_DEFAULT   = 24;

    // Result field widths
    localparam int KIND_W  = 3;
    localparam int VALUE_W = 32;
    localparam int REC_W   = 24;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_RESIDUE = 3'd0;
    localparam logic [KIND_W-1:0] KIND_HEADER  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_START   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LENGTH  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_END     = 3'd4;

    // Characters of interest
    localparam logic [7:0] CHAR_NL = 8'h0A;
    localparam logic [7:0] CHAR_GT = 8'h3E;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One queued command: an optional length result ahead of the main result
    typedef struct packed {
        logic               has_len;
        logic [VALUE_W-1:0] len_value;
        logic [REC_W-1:0]   len_rec;
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        logic [REC_W-1:0]   rec;
        logic               last;
    } frsp_entry_t;

    // Queue status seen by front and back
    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } frsp_qstat_t;

endpackage

[design/frsp_front.sv]
module frsp_front
    import frsp_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT,
    parameter int RECORD_BITS   = RECORD_BITS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        in_end,
    input  frsp_qstat_t qstat,
    output logic        push,
    output frsp_entry_t push_entry
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
    localparam logic [RECORD_BITS-1:0]   REC_MAX = '1;

    logic                     at_ls_reg, at_ls_next;
    logic                     in_hdr_reg, in_hdr_next;
    logic                     in_body_reg, in_body_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] res_reg, res_next;
    logic [RECORD_BITS-1:0]   recs_reg, recs_next;

    logic                     accept;
    logic [POSITION_BITS-1:0] pos_inc;
    logic [RECORD_BITS-1:0]   body_rec;
    logic                     is_lower;
    logic                     is_upper;

    assign in_ready = !qstat.full;
    assign accept   = in_valid && in_ready;
    assign pos_inc  = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;
    assign body_rec = (recs_reg == '0) ? '0 : recs_reg - 1'b1;
    assign is_lower = (in_byte >= 8'h61) && (in_byte <= 8'h7A);
    assign is_upper = (in_byte >= 8'h41) && (in_byte <= 8'h5A);

    // Classify the byte and build the command for the back end
    always_comb begin
        at_ls_next   = at_ls_reg;
        in_hdr_next  = in_hdr_reg;
        in_body_next = in_body_reg;
        pos_next     = pos_reg;
        res_next     = res_reg;
        recs_next    = recs_reg;
        push         = 1'b0;
        push_entry   = '0;
        if (accept) begin
            if (in_end) begin
                // close open body, report count, return to reset state
                push                 = 1'b1;
                push_entry.has_len   = in_body_reg;
                push_entry.len_value = VALUE_W'(res_reg);
                push_entry.len_rec   = REC_W'(body_rec);
                push_entry.kind      = KIND_END;
                push_entry.value     = VALUE_W'(recs_reg);
                push_entry.rec       = REC_W'(recs_reg);
                push_entry.last      = 1'b1;
                at_ls_next           = 1'b1;
                in_hdr_next          = 1'b1;
                in_body_next         = 1'b0;
                pos_next             = '0;
                res_next             = '0;
                recs_next            = '0;
            end else begin
                pos_next = pos_inc;
                if (in_byte == CHAR_NL) begin
                    at_ls_next = 1'b1;
                    if (in_hdr_reg) begin
                        push             = 1'b1;
                        push_entry.kind  = KIND_START;
                        push_entry.value = VALUE_W'(pos_inc);
                        push_entry.rec   = REC_W'(recs_reg);
                        recs_next        = (recs_reg == REC_MAX) ? recs_reg : recs_reg + 1'b1;
                        in_hdr_next      = 1'b0;
                        in_body_next     = 1'b1;
                        res_next         = '0;
                    end
                end else if (in_byte == CHAR_GT && at_ls_reg) begin
                    at_ls_next = 1'b0;
                    if (in_body_reg) begin
                        push             = 1'b1;
                        push_entry.kind  = KIND_LENGTH;
                        push_entry.value = VALUE_W'(res_reg);
                        push_entry.rec   = REC_W'(body_rec);
                    end
                    in_body_next = 1'b0;
                    in_hdr_next  = 1'b1;
                end else begin
                    at_ls_next = 1'b0;
                    if (in_hdr_reg) begin
                        push             = 1'b1;
                        push_entry.kind  = KIND_HEADER;
                        push_entry.value = VALUE_W'(in_byte);
                        push_entry.rec   = REC_W'(recs_reg);
                    end else if (in_body_reg && (is_lower || is_upper)) begin
                        push             = 1'b1;
                        push_entry.kind  = KIND_RESIDUE;
                        push_entry.value = VALUE_W'(is_lower ? in_byte - 8'd32 : in_byte);
                        push_entry.rec   = REC_W'(body_rec);
                        res_next         = (res_reg == POS_MAX) ? res_reg : res_reg + 1'b1;
                    end
                end
            end
        end
    end

    // Parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            at_ls_reg   <= 1'b1;
            in_hdr_reg  <= 1'b1;
            in_body_reg <= 1'b0;
            pos_reg     <= '0;
            res_reg     <= '0;
            recs_reg    <= '0;
        end else begin
            at_ls_reg   <= at_ls_next;
            in_hdr_reg  <= in_hdr_next;
            in_body_reg <= in_body_next;
            pos_reg     <= pos_next;
            res_reg     <= res_next;
            recs_reg    <= recs_next;
        end
    end

endmodule

[design/frsp_queue.sv]
module frsp_queue
    import frsp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  frsp_entry_t push_entry,
    input  logic        pop,
    output frsp_entry_t head,
    output frsp_qstat_t qstat
);

    frsp_entry_t       mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign qstat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign qstat.count = count_reg;
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign head        = mem[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

[design/frsp_back.sv]
module frsp_back
    import frsp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  frsp_entry_t         head,
    input  frsp_qstat_t         qstat,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [KIND_W-1:0]   out_kind,
    output logic [VALUE_W-1:0]  out_value,
    output logic [REC_W-1:0]    out_rec,
    output logic                out_last
);

    logic               valid_reg, valid_next;
    logic               len_done_reg, len_done_next;
    logic [KIND_W-1:0]  kind_reg, kind_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic [REC_W-1:0]   rec_reg, rec_next;
    logic               last_reg, last_next;
    logic               load;

    assign load = !valid_reg || out_ready;

    // Expand a command into one or two results
    always_comb begin
        valid_next    = valid_reg && !out_ready;
        len_done_next = len_done_reg;
        kind_next     = kind_reg;
        value_next    = value_reg;
        rec_next      = rec_reg;
        last_next     = last_reg;
        pop           = 1'b0;
        if (load && !qstat.empty) begin
            valid_next = 1'b1;
            if (head.has_len && !len_done_reg) begin
                len_done_next = 1'b1;
                kind_next     = KIND_LENGTH;
                value_next    = head.len_value;
                rec_next      = head.len_rec;
                last_next     = 1'b0;
            end else begin
                pop           = 1'b1;
                len_done_next = 1'b0;
                kind_next     = head.kind;
                value_next    = head.value;
                rec_next      = head.rec;
                last_next     = head.last;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= 1'b0;
            len_done_reg <= 1'b0;
        end else begin
            valid_reg    <= valid_next;
            len_done_reg <= len_done_next;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        kind_reg  <= kind_next;
        value_reg <= value_next;
        rec_reg   <= rec_next;
        last_reg  <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_value = value_reg;
    assign out_rec   = rec_reg;
    assign out_last  = last_reg;

endmodule

[design/fasta_record_stream_parser.sv]
// A result leaves on m_ after its byte is accepted and has passed the command queue and the output register.
// Throughput: one byte per cycle unless the queue is full; the output register issues one result per ready cycle.
// The end marker with an open sequence body yields two results,
// absorbed by the four-entry command queue between parser and output stage.
// Reset: synchronous on aresetn low; parser state, queue and output valid are cleared.
module fasta_record_stream_parser
    import frsp_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT,
    parameter int RECORD_BITS   = RECORD_BITS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [31:0] value, [55:32] record_number
    output logic [2:0]  m_tuser,   // [2:0] kind
    output logic        m_tlast    // last
);

    frsp_entry_t        push_entry;
    frsp_entry_t        head;
    frsp_qstat_t        qstat;
    logic               push;
    logic               pop;
    logic [VALUE_W-1:0] out_value;
    logic [REC_W-1:0]   out_rec;

    // Parser front end
    frsp_front #(
        .POSITION_BITS (POSITION_BITS),
        .RECORD_BITS   (RECORD_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .in_end     (s_tlast),
        .qstat      (qstat),
        .push       (push),
        .push_entry (push_entry)
    );

    // Command queue
    frsp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .qstat      (qstat)
    );

    // Output stage
    frsp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head),
        .qstat     (qstat),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_kind  (m_tuser),
        .out_value (out_value),
        .out_rec   (out_rec),
        .out_last  (m_tlast)
    );

    assign m_tdata = {out_rec, out_value};

`ifndef NO_ASSERTIONS
    // Queue never overfills
    assert property (@(posedge aclk) disable iff (!aresetn)
        qstat.count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

    // Input stalls only when the queue is full
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> qstat.full)
        else $error("input stalled with queue space");

    // Last flag goes with the end result only
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser == KIND_END)))
        else $error("last flag and kind disagree");

    // A push only follows an accepted input byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (s_tvalid && s_tready))
        else $error("queue write without input transaction");
`endif

endmodule
